### sv/lpe_pkg.sv
// Shared types and constants of the LED pixel PWM encoder.
package lpe_pkg;

  localparam int BITS_PER_PIXEL = 24;
  localparam int DUTY_W         = 16;
  localparam int FACTOR_W       = 25;
  localparam int RECIP_SHIFT    = 24;
  localparam int CFG_IDX_W      = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_DUTY_ZERO  = 2'd1,
    REG_DUTY_ONE   = 2'd2
  } cfg_reg_t;

  // brightness as seen by the scalers: bypass flag and fixed-point factor
  typedef struct packed {
    logic                full;
    logic [FACTOR_W-1:0] factor;
  } scale_cfg_t;

endpackage

### sv/lpe_pixel_if.sv
// Pixel input channel: valid/ready handshake with color bytes and frame-end flag.
interface lpe_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] green;
  logic [7:0] red;
  logic [7:0] blue;
  logic       last_pixel;

  modport source (output valid, green, red, blue, last_pixel, input ready);
  modport sink   (input valid, green, red, blue, last_pixel, output ready);
endinterface

### sv/lpe_word_if.sv
// Duty word output channel: valid/ready handshake with one PWM compare word.
interface lpe_word_if;
  logic                        valid;
  logic                        ready;
  logic [lpe_pkg::DUTY_W-1:0]  duty;
  logic                        reset_slot;
  logic                        last_of_run;

  modport source (output valid, duty, reset_slot, last_of_run, input ready);
  modport sink   (input valid, duty, reset_slot, last_of_run, output ready);
endinterface

### sv/lpe_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
interface lpe_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lpe_pkg::CFG_IDX_W-1:0] index;
  logic [lpe_pkg::DUTY_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/lpe_scale.sv
// Brightness scaler for one color byte: reciprocal multiply, or bypass at full.
module lpe_scale (
  input  logic [7:0]          byte_in,
  input  lpe_pkg::scale_cfg_t cfg,
  output logic [7:0]          byte_out
);

  logic [32:0] prod;

  // factor already folds brightness and 1/BRIGHT_FULL; the result is exact
  assign prod = 33'(byte_in) * 33'(cfg.factor);

  always_comb begin
    if (cfg.full) begin
      byte_out = byte_in;
    end else begin
      byte_out = prod[lpe_pkg::RECIP_SHIFT +: 8];
    end
  end

endmodule

### sv/led_pixel_pwm_encoder_core.sv
// Top level of the LED pixel PWM encoder: pixel register, bit serializer, word register.
//
//   channel   dir   beat contents
//   in_px     in    green, red, blue, last_pixel
//   out_wd    out   duty, reset_slot, last_of_run
//   cfg_wr    in    index, data (brightness, duty_zero, duty_one)
//
// One duty word leaves per cycle while out_wd is ready: a pixel yields 24 words, or 24 + RESET_SLOTS when last.
// The serializer's word counter sets that figure; the next pixel waits in the input
// register and is scaled and loaded in the cycle its predecessor's final word moves.
// rst_n is synchronous, active low; it empties all stages and restores register defaults.
// A stalled out_wd holds its word and the serializer; in_px stalls once the
// input register is full.
module led_pixel_pwm_encoder_core #(
  parameter int BRIGHT_FULL = 255,
  parameter int RESET_SLOTS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  lpe_pixel_if.sink      in_px,
  lpe_word_if.source     out_wd,
  lpe_cfg_if.sink        cfg_wr
);

  localparam int CNT_W = $clog2(lpe_pkg::BITS_PER_PIXEL + RESET_SLOTS);
  localparam logic [CNT_W-1:0] LAST_DATA = CNT_W'(lpe_pkg::BITS_PER_PIXEL - 1);
  localparam logic [CNT_W-1:0] LAST_PAD  =
    CNT_W'(lpe_pkg::BITS_PER_PIXEL + RESET_SLOTS - 1);
  localparam logic [CNT_W-1:0] DATA_END  = CNT_W'(lpe_pkg::BITS_PER_PIXEL);
  localparam logic [7:0] FULL_LVL = 8'(BRIGHT_FULL);
  localparam logic [lpe_pkg::FACTOR_W-1:0] RECIP =
    lpe_pkg::FACTOR_W'(((2 ** lpe_pkg::RECIP_SHIFT) + BRIGHT_FULL - 1) / BRIGHT_FULL);

  // configuration
  lpe_pkg::scale_cfg_t            scale_r;
  logic [lpe_pkg::DUTY_W-1:0]     duty_zero_r;
  logic [lpe_pkg::DUTY_W-1:0]     duty_one_r;
  logic [7:0]                     bright_clip;
  logic [32:0]                    factor_prod;
  logic                           cfg_fire;

  // input register
  logic                           pix_valid_r;
  logic [7:0]                     pix_g_r;
  logic [7:0]                     pix_r_r;
  logic [7:0]                     pix_b_r;
  logic                           pix_last_r;

  // serializer
  logic                           ser_active_r;
  logic [lpe_pkg::BITS_PER_PIXEL-1:0] shift_r;
  logic [CNT_W-1:0]               cnt_r;
  logic                           pad_r;

  // output register
  logic                           out_valid_r;
  logic [lpe_pkg::DUTY_W-1:0]     out_duty_r;
  logic                           out_rs_r;
  logic                           out_last_r;

  logic [7:0]                     g_scaled;
  logic [7:0]                     r_scaled;
  logic [7:0]                     b_scaled;
  logic                           adv;
  logic                           emit;
  logic                           word_last;
  logic                           is_data;
  logic                           load;
  logic                           in_fire;

  assign cfg_wr.ready = 1'b1;
  assign cfg_fire     = cfg_wr.valid && cfg_wr.ready;

  always_comb begin
    if (cfg_wr.data[7:0] > FULL_LVL) begin
      bright_clip = FULL_LVL;
    end else begin
      bright_clip = cfg_wr.data[7:0];
    end
  end

  assign factor_prod = 33'(bright_clip) * 33'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r.full   <= 1'b1;
      scale_r.factor <= '0;
      duty_zero_r    <= '0;
      duty_one_r     <= '0;
    end else if (cfg_fire) begin
      unique case (lpe_pkg::cfg_reg_t'(cfg_wr.index))
        lpe_pkg::REG_BRIGHTNESS: begin
          scale_r.full   <= (bright_clip >= FULL_LVL);
          scale_r.factor <= factor_prod[lpe_pkg::FACTOR_W-1:0];
        end
        lpe_pkg::REG_DUTY_ZERO: duty_zero_r <= cfg_wr.data;
        lpe_pkg::REG_DUTY_ONE:  duty_one_r  <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  lpe_scale u_scale_g (.byte_in(pix_g_r), .cfg(scale_r), .byte_out(g_scaled));
  lpe_scale u_scale_r (.byte_in(pix_r_r), .cfg(scale_r), .byte_out(r_scaled));
  lpe_scale u_scale_b (.byte_in(pix_b_r), .cfg(scale_r), .byte_out(b_scaled));

  assign adv       = !out_valid_r || out_wd.ready;
  assign emit      = ser_active_r && adv;
  assign is_data   = cnt_r < DATA_END;
  assign word_last = pad_r ? (cnt_r == LAST_PAD) : (cnt_r == LAST_DATA);
  assign load      = pix_valid_r && (!ser_active_r || (emit && word_last));

  assign in_px.ready = !pix_valid_r || load;
  assign in_fire     = in_px.valid && in_px.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
    end else if (in_fire) begin
      pix_valid_r <= 1'b1;
    end else if (load) begin
      pix_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pix_g_r    <= in_px.green;
      pix_r_r    <= in_px.red;
      pix_b_r    <= in_px.blue;
      pix_last_r <= in_px.last_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_active_r <= 1'b0;
      shift_r      <= '0;
      cnt_r        <= '0;
      pad_r        <= 1'b0;
    end else if (load) begin
      ser_active_r <= 1'b1;
      shift_r      <= {g_scaled, r_scaled, b_scaled};
      cnt_r        <= '0;
      pad_r        <= pix_last_r;
    end else if (emit) begin
      ser_active_r <= !word_last;
      shift_r      <= {shift_r[lpe_pkg::BITS_PER_PIXEL-2:0], 1'b0};
      cnt_r        <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ser_active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_rs_r   <= !is_data;
      out_last_r <= word_last;
      if (!is_data) begin
        out_duty_r <= '0;
      end else if (shift_r[lpe_pkg::BITS_PER_PIXEL-1]) begin
        out_duty_r <= duty_one_r;
      end else begin
        out_duty_r <= duty_zero_r;
      end
    end
  end

  assign out_wd.valid       = out_valid_r;
  assign out_wd.duty        = out_duty_r;
  assign out_wd.reset_slot  = out_rs_r;
  assign out_wd.last_of_run = out_last_r;

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rs_r |-> out_duty_r == '0)
    else $error("latch word with nonzero duty");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ser_active_r |-> (cnt_r <= LAST_PAD) && (pad_r || (cnt_r <= LAST_DATA)))
    else $error("serializer word count out of range");

  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> ser_active_r && cnt_r == '0)
    else $error("serializer not started after load");

endmodule

### tb/tb.sv
// Self-checking testbench for the LED pixel PWM encoder: directed table, then random pixels.
module tb #(
  parameter int BRIGHT_FULL = 255,
  parameter int RESET_SLOTS = 32
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [lpe_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 2000;
  localparam int RAND_PIXELS   = 46;

  typedef struct packed {
    logic [lpe_pkg::DUTY_W-1:0] duty;
    logic                       reset_slot;
    logic                       last_of_run;
  } duty_word_t;

  typedef enum logic {ROW_CFG, ROW_PIXEL} row_kind_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [lpe_pkg::CFG_IDX_W-1:0] idx;
    logic [lpe_pkg::DUTY_W-1:0]    data;
    logic [7:0]                    green;
    logic [7:0]                    red;
    logic [7:0]                    blue;
    logic                          last_pixel;
    logic                          typed;
    logic [23:0]                   bits;
  } plan_row_t;

  // typed rows carry the scaled G,R,B bits; the others go through scaled_color
  localparam plan_row_t PLAN [25] = '{
    '{ROW_PIXEL, REG_NONE,                16'h0000, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b1, 24'hFF00FF},
    '{ROW_CFG,   lpe_pkg::REG_DUTY_ZERO,  16'h0001, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_CFG,   lpe_pkg::REG_DUTY_ONE,   16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_NONE,                16'h0000, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 24'h000000},
    '{ROW_PIXEL, REG_NONE,                16'h0000, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 24'hFFFFFF},
    '{ROW_PIXEL, REG_NONE,                16'h0000, 8'hA5, 8'h5A, 8'hC3, 1'b0, 1'b1, 24'hA55AC3},
    '{ROW_CFG,   lpe_pkg::REG_BRIGHTNESS, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_NONE,                16'h0000, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 24'h000000},
    '{ROW_CFG,   lpe_pkg::REG_BRIGHTNESS, 16'h0001, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_NONE,                16'h0000, 8'hFF, 8'h80, 8'h01, 1'b0, 1'b1, 24'h010000},
    '{ROW_CFG,   lpe_pkg::REG_BRIGHTNESS, 16'h0080, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_NONE,                16'h0000, 8'hFF, 8'h7F, 8'h01, 1'b0, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_NONE,                16'h0000, 8'h3C, 8'h96, 8'hE1, 1'b1, 1'b0, 24'h000000},
    '{ROW_CFG,   lpe_pkg::REG_BRIGHTNESS, 16'h00FE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_NONE,                16'h0000, 8'hFE, 8'hFF, 8'h80, 1'b0, 1'b0, 24'h000000},
    '{ROW_CFG,   lpe_pkg::REG_BRIGHTNESS, 16'h01FF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_NONE,                16'h0000, 8'h12, 8'h34, 8'h56, 1'b0, 1'b1, 24'h123456},
    '{ROW_CFG,   lpe_pkg::REG_BRIGHTNESS, 16'hFF00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_NONE,                16'h0000, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 24'h000000},
    '{ROW_CFG,   lpe_pkg::REG_BRIGHTNESS, 16'h00FF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_CFG,   REG_NONE,                16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_NONE,                16'h0000, 8'h81, 8'h42, 8'h24, 1'b1, 1'b1, 24'h814224},
    '{ROW_CFG,   lpe_pkg::REG_DUTY_ZERO,  16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_CFG,   lpe_pkg::REG_DUTY_ONE,   16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 24'h000000},
    '{ROW_PIXEL, REG_NONE,                16'h0000, 8'hF0, 8'h0F, 8'h3C, 1'b1, 1'b1, 24'hF00F3C}
  };

  logic clk = 1'b0;
  logic rst_n;

  lpe_pixel_if px_bus ();
  lpe_word_if  wd_bus ();
  lpe_cfg_if   cfg_bus ();

  led_pixel_pwm_encoder_core #(
    .BRIGHT_FULL (BRIGHT_FULL),
    .RESET_SLOTS (RESET_SLOTS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (px_bus),
    .out_wd (wd_bus),
    .cfg_wr (cfg_bus)
  );

  always #10 clk = ~clk;

  int                         bright_q     = (BRIGHT_FULL < 255) ? BRIGHT_FULL : 255;
  logic [lpe_pkg::DUTY_W-1:0] duty_zero_q  = '0;
  logic [lpe_pkg::DUTY_W-1:0] duty_one_q   = '0;
  duty_word_t                 words_due[$];
  logic                       any_mismatch = 1'b0;
  int                         send_idle    = 0;
  int                         recv_idle    = 0;
  int                         stall_cycles = 0;
  duty_word_t                 due;

  function automatic logic [23:0] scaled_color(logic [7:0] g, logic [7:0] r, logic [7:0] b);
    logic [23:0] px;
    px = {g, r, b};
    if (bright_q < BRIGHT_FULL)
      for (int k = 0; k < 3; k++)
        px[8*k +: 8] = 8'((int'(px[8*k +: 8]) * bright_q) / BRIGHT_FULL);
    return px;
  endfunction

  function automatic void queue_pixel_words(logic [23:0] bits, logic last_pixel);
    int         total;
    duty_word_t w;
    total = lpe_pkg::BITS_PER_PIXEL + (last_pixel ? RESET_SLOTS : 0);
    for (int n = 0; n < total; n++) begin
      if (n < lpe_pkg::BITS_PER_PIXEL) begin
        w.duty       = bits[lpe_pkg::BITS_PER_PIXEL-1-n] ? duty_one_q : duty_zero_q;
        w.reset_slot = 1'b0;
      end else begin
        w.duty       = '0;
        w.reset_slot = 1'b1;
      end
      w.last_of_run = (n + 1 == total);
      words_due.push_back(w);
    end
  endfunction

  // valid stays high on return so back-to-back beats need no re-raise
  task automatic send_pixel(logic [7:0] g, logic [7:0] r, logic [7:0] b, logic last_pixel,
                            logic typed, logic [23:0] bits);
    px_bus.valid      <= 1'b1;
    px_bus.green      <= g;
    px_bus.red        <= r;
    px_bus.blue       <= b;
    px_bus.last_pixel <= last_pixel;
    do @(posedge clk); while (!px_bus.ready);
    queue_pixel_words(typed ? bits : scaled_color(g, r, b), last_pixel);
  endtask

  task automatic write_reg(logic [lpe_pkg::CFG_IDX_W-1:0] idx,
                           logic [lpe_pkg::DUTY_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      lpe_pkg::REG_BRIGHTNESS: bright_q = (int'(value[7:0]) > BRIGHT_FULL) ? BRIGHT_FULL
                                                                          : int'(value[7:0]);
      lpe_pkg::REG_DUTY_ZERO:  duty_zero_q = value;
      lpe_pkg::REG_DUTY_ONE:   duty_one_q  = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic settle();
    px_bus.valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    wd_bus.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && wd_bus.valid && wd_bus.ready) begin
      if (words_due.size() == 0) begin
        $display("%0t: unexpected word: expected none, got duty %h reset_slot %b last %b",
                 $time, wd_bus.duty, wd_bus.reset_slot, wd_bus.last_of_run);
        any_mismatch = 1'b1;
      end else begin
        due = words_due.pop_front();
        if (wd_bus.duty !== due.duty) begin
          $display("%0t: duty mismatch: expected %h, got %h", $time, due.duty, wd_bus.duty);
          any_mismatch = 1'b1;
        end
        if (wd_bus.reset_slot !== due.reset_slot) begin
          $display("%0t: reset_slot mismatch: expected %b, got %b",
                   $time, due.reset_slot, wd_bus.reset_slot);
          any_mismatch = 1'b1;
        end
        if (wd_bus.last_of_run !== due.last_of_run) begin
          $display("%0t: last_of_run mismatch: expected %b, got %b",
                   $time, due.last_of_run, wd_bus.last_of_run);
          any_mismatch = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (px_bus.valid && px_bus.ready) || (wd_bus.valid && wd_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [lpe_pkg::DUTY_W-1:0] bval;
    logic [lpe_pkg::DUTY_W-1:0] d0;
    logic [lpe_pkg::DUTY_W-1:0] d1;

    rst_n             <= 1'b0;
    px_bus.valid      <= 1'b0;
    px_bus.green      <= '0;
    px_bus.red        <= '0;
    px_bus.blue       <= '0;
    px_bus.last_pixel <= 1'b0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= lpe_pkg::REG_BRIGHTNESS;
    cfg_bus.data      <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_CFG) begin
        settle();
        write_reg(PLAN[i].idx, PLAN[i].data);
      end else begin
        send_pixel(PLAN[i].green, PLAN[i].red, PLAN[i].blue, PLAN[i].last_pixel,
                   PLAN[i].typed, PLAN[i].bits);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 13 : (mode == 1) ? 87 : 0;
      recv_idle = (mode == 0) ? 87 : (mode == 1) ? 13 : 0;
      for (int k = 0; k < RAND_PIXELS; k++) begin
        if (k % 10 == 0) begin
          settle();
          case ($urandom_range(4))
            0:       bval = '0;
            1:       bval = 16'(BRIGHT_FULL);
            2:       bval = 16'($urandom_range(1, 254));
            3:       bval = 16'($urandom);
            default: bval = 16'd1;
          endcase
          d0 = ($urandom_range(3) == 0) ? 16'hFFFF :
               ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
          d1 = ($urandom_range(3) == 0) ? 16'hFFFF :
               ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
          write_reg(lpe_pkg::REG_BRIGHTNESS, bval);
          write_reg(lpe_pkg::REG_DUTY_ZERO, d0);
          write_reg(lpe_pkg::REG_DUTY_ONE, d1);
          if ($urandom_range(3) == 0) write_reg(REG_NONE, 16'($urandom));
        end
        if (send_idle != 0 && $urandom_range(99) < send_idle) begin
          px_bus.valid <= 1'b0;
          do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom), ($urandom_range(3) == 0),
                   1'b0, 24'h000000);
      end
    end

    settle();
    if (!any_mismatch) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
